// ===== hdl/pcen_pkg.sv =====
// ----------------------------------------------------------------------------
// pcen_pkg: shared constants and types for the polygon centroid block
// Widths of the coordinate, accumulator and quotient paths, plus the request
// and status bundles that pass between the sequencer and its two units.
// ----------------------------------------------------------------------------
`default_nettype none

package pcen_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 23;

  // x0*y1 - x1*y0 needs one bit more than a single product
  localparam int CROSS_BITS = 2 * COORD_BITS + 1;
  localparam int SUM_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = SUM_BITS + CROSS_BITS;
  localparam int AREA_BITS  = 48;
  localparam int MOM_BITS   = 64;
  // 3 * |area| fits one bit over the area width
  localparam int DEN_BITS   = AREA_BITS + 1;
  localparam int QUO_BITS   = OUT_BITS;
  localparam int INT_BITS   = QUO_BITS - FRAC_BITS;
  localparam int CNT_BITS   = $clog2(QUO_BITS);

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic                  start;
    logic                  clear;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } edge_req_t;

  typedef struct packed {
    logic                 done;
    logic [AREA_BITS-1:0] area;
    logic [MOM_BITS-1:0]  mx;
    logic [MOM_BITS-1:0]  my;
  } edge_sts_t;

  typedef struct packed {
    logic                start;
    logic [MOM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quo;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== hdl/pcen_edge.sv =====
// ----------------------------------------------------------------------------
// pcen_edge: shoelace edge accumulator on one shared multiplier
// Runs four multiplies in turn per edge and folds the cross product and the
// two moments into the running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pcen_edge (
  input  wire                 clk,
  input  wire                 rst_n,
  input  pcen_pkg::edge_req_t req,
  output pcen_pkg::edge_sts_t sts
);

  typedef enum logic [2:0] {
    E_IDLE, E_P0, E_P1, E_SUB, E_MX, E_MY, E_ACC
  } est_t;

  est_t                            state_r;
  logic [pcen_pkg::COORD_BITS-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [pcen_pkg::CROSS_BITS-1:0] cross_r;
  logic [pcen_pkg::PROD_BITS-1:0]  prod_r;
  logic [pcen_pkg::AREA_BITS-1:0]  area_r;
  logic [pcen_pkg::MOM_BITS-1:0]   mx_r, my_r;

  logic signed [pcen_pkg::SUM_BITS-1:0]   sum_x, sum_y;
  logic signed [pcen_pkg::SUM_BITS-1:0]   mul_a;
  logic signed [pcen_pkg::CROSS_BITS-1:0] mul_b;
  logic signed [pcen_pkg::PROD_BITS-1:0]  mul_p;

  always_comb begin
    sum_x = pcen_pkg::SUM_BITS'($signed(x0_r)) + pcen_pkg::SUM_BITS'($signed(x1_r));
    sum_y = pcen_pkg::SUM_BITS'($signed(y0_r)) + pcen_pkg::SUM_BITS'($signed(y1_r));
    case (state_r)
      E_P0: begin
        mul_a = pcen_pkg::SUM_BITS'($signed(x0_r));
        mul_b = pcen_pkg::CROSS_BITS'($signed(y1_r));
      end
      E_P1: begin
        mul_a = pcen_pkg::SUM_BITS'($signed(x1_r));
        mul_b = pcen_pkg::CROSS_BITS'($signed(y0_r));
      end
      E_MY: begin
        mul_a = sum_y;
        mul_b = $signed(cross_r);
      end
      default: begin
        mul_a = sum_x;
        mul_b = $signed(cross_r);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      area_r  <= '0;
      mx_r    <= '0;
      my_r    <= '0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (req.clear) begin
            area_r <= '0;
            mx_r   <= '0;
            my_r   <= '0;
          end else if (req.start) begin
            x0_r    <= req.ax;
            y0_r    <= req.ay;
            x1_r    <= req.bx;
            y1_r    <= req.by;
            state_r <= E_P0;
          end
        end
        E_P0: begin
          prod_r  <= mul_p;
          state_r <= E_P1;
        end
        E_P1: begin
          cross_r <= prod_r[pcen_pkg::CROSS_BITS-1:0];
          prod_r  <= mul_p;
          state_r <= E_SUB;
        end
        E_SUB: begin
          cross_r <= cross_r - prod_r[pcen_pkg::CROSS_BITS-1:0];
          state_r <= E_MX;
        end
        E_MX: begin
          prod_r  <= mul_p;
          area_r  <= area_r + pcen_pkg::AREA_BITS'($signed(cross_r));
          state_r <= E_MY;
        end
        E_MY: begin
          prod_r  <= mul_p;
          mx_r    <= mx_r + pcen_pkg::MOM_BITS'($signed(prod_r));
          state_r <= E_ACC;
        end
        E_ACC: begin
          my_r    <= my_r + pcen_pkg::MOM_BITS'($signed(prod_r));
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  // sums settle in the cycle after done
  assign sts.done = (state_r == E_ACC);
  assign sts.area = area_r;
  assign sts.mx   = mx_r;
  assign sts.my   = my_r;

endmodule

`default_nettype wire

// ===== hdl/pcen_div.sv =====
// ----------------------------------------------------------------------------
// pcen_div: restoring divider, one quotient bit per cycle
// Gives min(num * 2^FRAC_BITS / den, OUT_MAX); overflow caught up front.
// ----------------------------------------------------------------------------
`default_nettype none

module pcen_div (
  input  wire                clk,
  input  wire                rst_n,
  input  pcen_pkg::div_req_t req,
  output pcen_pkg::div_sts_t sts
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dst_t;

  dst_t                          state_r;
  logic [pcen_pkg::DEN_BITS-1:0] den_r, rem_r;
  logic [pcen_pkg::QUO_BITS-1:0] shf_r, quo_r;
  logic [pcen_pkg::CNT_BITS-1:0] cnt_r;

  logic [pcen_pkg::MOM_BITS:0]   hi_ext, den_ext;
  logic                          sat;
  logic [pcen_pkg::QUO_BITS-1:0] low_bits;
  logic [pcen_pkg::DEN_BITS:0]   trial, diff;
  logic                          ge;
  logic [pcen_pkg::DEN_BITS-1:0] rem_nxt;

  always_comb begin
    hi_ext   = (pcen_pkg::MOM_BITS+1)'(req.num >> pcen_pkg::INT_BITS);
    den_ext  = (pcen_pkg::MOM_BITS+1)'(req.den);
    sat      = (hi_ext >= den_ext);
    low_bits = {req.num[pcen_pkg::INT_BITS-1:0], pcen_pkg::FRAC_BITS'(0)};
    trial    = {rem_r, shf_r[pcen_pkg::QUO_BITS-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    rem_nxt  = ge ? diff[pcen_pkg::DEN_BITS-1:0] : trial[pcen_pkg::DEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            den_r <= req.den;
            if (sat) begin
              quo_r   <= pcen_pkg::OUT_MAX;
              state_r <= D_DONE;
            end else begin
              rem_r   <= pcen_pkg::DEN_BITS'(hi_ext);
              shf_r   <= low_bits;
              quo_r   <= '0;
              cnt_r   <= '0;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt;
          shf_r <= shf_r << 1;
          quo_r <= {quo_r[pcen_pkg::QUO_BITS-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pcen_pkg::CNT_BITS'(pcen_pkg::QUO_BITS - 1)) begin
            state_r <= D_DONE;
          end
        end
        D_DONE:  state_r <= D_IDLE;
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign sts.done = (state_r == D_DONE);
  assign sts.quo  = quo_r;

endmodule

`default_nettype wire

// ===== hdl/polygon_centroid.sv =====
// ----------------------------------------------------------------------------
// polygon_centroid: streaming shoelace centroid of a simple polygon
// Sequencer around a shared-multiplier edge unit and a bit-serial divider.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                       | item
//  ---------+---------------------------------------------+---------------------
//  in       | in_valid/in_ready, in_vertex_x/y, in_is_last | one vertex
//  out      | out_valid/out_ready, out_centroid_x/y,       | one centroid per
//           | out_degenerate                               | polygon
//
//  A vertex after the first keeps in_ready low from its accept until the
//  edge unit is started and has run six steps for its four multiplies
//  and three accumulates through a single 17x33 multiplier. A first vertex
//  that is not the last is only stored. The last vertex adds the closing edge
//  and two 23-step divisions, one quotient bit a cycle; a divide that
//  saturates skips its 23 steps, and a zero area skips both divisions.
//  in_ready is high only while the sequencer idles; a finished item waits in
//  the output register, so the next polygon may start while it is unread,
//  and its own result stalls in the output step until that register frees.
//  Synchronous active-low reset clears the sums and the sequencer.
//
`default_nettype none

module polygon_centroid (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire signed [pcen_pkg::COORD_BITS-1:0] in_vertex_x,
  input  wire signed [pcen_pkg::COORD_BITS-1:0] in_vertex_y,
  input  wire                                   in_is_last,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [pcen_pkg::OUT_BITS-1:0]         out_centroid_x,
  output logic [pcen_pkg::OUT_BITS-1:0]         out_centroid_y,
  output logic                                  out_degenerate
);

  typedef enum logic [2:0] {
    T_IDLE, T_EDGE, T_CLOSE, T_PREP, T_DIVX, T_DIVY, T_OUT
  } tst_t;

  tst_t                            state_r;
  logic                            have_first_r;
  logic                            last_r;
  logic [pcen_pkg::COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  // edge operands, held for the edge unit to latch on start
  logic [pcen_pkg::COORD_BITS-1:0] ea_x_r, ea_y_r, eb_x_r, eb_y_r;
  logic                            estart_r, dstart_r;
  logic [pcen_pkg::DEN_BITS-1:0]   den_r;
  logic [pcen_pkg::MOM_BITS-1:0]   magx_r, magy_r;
  logic                            degen_r;
  logic [pcen_pkg::OUT_BITS-1:0]   qx_r, qy_r;
  logic                            out_valid_r;
  logic [pcen_pkg::OUT_BITS-1:0]   cx_r, cy_r;
  logic                            dg_r;

  pcen_pkg::edge_req_t edge_req;
  pcen_pkg::edge_sts_t edge_sts;
  pcen_pkg::div_req_t  div_req;
  pcen_pkg::div_sts_t  div_sts;

  logic                           in_acc;
  logic                           out_load;
  logic [pcen_pkg::AREA_BITS-1:0] area_mag;
  logic [pcen_pkg::DEN_BITS-1:0]  den3;
  logic [pcen_pkg::MOM_BITS-1:0]  magx, magy;
  logic                           area_zero;

  assign in_ready = (state_r == T_IDLE);
  assign in_acc   = in_valid && in_ready;
  // output register free, or being emptied this cycle
  assign out_load = (state_r == T_OUT) && (!out_valid_r || out_ready);

  // magnitudes for the divide; 3*|area| as a + 2a
  always_comb begin
    area_zero = (edge_sts.area == '0);
    area_mag  = edge_sts.area[pcen_pkg::AREA_BITS-1] ? (~edge_sts.area + 1'b1)
                                                      : edge_sts.area;
    den3      = {1'b0, area_mag} + {area_mag, 1'b0};
    magx      = edge_sts.mx[pcen_pkg::MOM_BITS-1] ? (~edge_sts.mx + 1'b1) : edge_sts.mx;
    magy      = edge_sts.my[pcen_pkg::MOM_BITS-1] ? (~edge_sts.my + 1'b1) : edge_sts.my;
  end

  assign edge_req.start = estart_r;
  assign edge_req.clear = out_load;
  assign edge_req.ax    = ea_x_r;
  assign edge_req.ay    = ea_y_r;
  assign edge_req.bx    = eb_x_r;
  assign edge_req.by    = eb_y_r;

  assign div_req.start = dstart_r;
  assign div_req.num   = (state_r == T_DIVY) ? magy_r : magx_r;
  assign div_req.den   = den_r;

  pcen_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (edge_req),
    .sts   (edge_sts)
  );

  pcen_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  // start pulses last one cycle: each is cleared in the state it leads into
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      have_first_r <= 1'b0;
      estart_r     <= 1'b0;
      dstart_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            prev_x_r <= in_vertex_x;
            prev_y_r <= in_vertex_y;
            last_r   <= in_is_last;
            eb_x_r   <= in_vertex_x;
            eb_y_r   <= in_vertex_y;
            if (have_first_r) begin
              // edge from the previous vertex
              ea_x_r   <= prev_x_r;
              ea_y_r   <= prev_y_r;
              estart_r <= 1'b1;
              state_r  <= T_EDGE;
            end else begin
              first_x_r    <= in_vertex_x;
              first_y_r    <= in_vertex_y;
              have_first_r <= 1'b1;
              estart_r     <= in_is_last;
              if (in_is_last) begin
                // lone vertex: closing edge is null, area comes out zero
                ea_x_r   <= in_vertex_x;
                ea_y_r   <= in_vertex_y;
                state_r  <= T_CLOSE;
              end
            end
          end
        end
        T_EDGE: begin
          estart_r <= edge_sts.done && last_r;
          if (edge_sts.done) begin
            if (last_r) begin
              // close back to the first vertex
              ea_x_r   <= prev_x_r;
              ea_y_r   <= prev_y_r;
              eb_x_r   <= first_x_r;
              eb_y_r   <= first_y_r;
              state_r  <= T_CLOSE;
            end else begin
              state_r <= T_IDLE;
            end
          end
        end
        T_CLOSE: begin
          estart_r <= 1'b0;
          if (edge_sts.done) begin
            state_r <= T_PREP;
          end
        end
        T_PREP: begin
          den_r    <= den3;
          magx_r   <= magx;
          magy_r   <= magy;
          degen_r  <= area_zero;
          dstart_r <= !area_zero;
          if (area_zero) begin
            qx_r    <= '0;
            qy_r    <= '0;
            state_r <= T_OUT;
          end else begin
            state_r  <= T_DIVX;
          end
        end
        T_DIVX: begin
          dstart_r <= div_sts.done;
          if (div_sts.done) begin
            qx_r     <= div_sts.quo;
            state_r  <= T_DIVY;
          end
        end
        T_DIVY: begin
          dstart_r <= 1'b0;
          if (div_sts.done) begin
            qy_r    <= div_sts.quo;
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            cx_r         <= qx_r;
            cy_r         <= qy_r;
            dg_r         <= degen_r;
            out_valid_r  <= 1'b1;
            have_first_r <= 1'b0;
            state_r      <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_centroid_x = cx_r;
  assign out_centroid_y = cy_r;
  assign out_degenerate = dg_r;

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_centroid_x == '0 && out_centroid_y == '0)
    else $error("degenerate result with non-zero centroid");

  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    edge_req.clear |-> !edge_req.start)
    else $error("edge sums cleared while an edge starts");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == T_OUT))
    else $error("result raised outside the output step");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("ready held after the closing vertex");
`endif

endmodule

`default_nettype wire
